FILE: rtl/aorr_pkg.sv
package aorr_pkg;

  localparam int ACTION_W = 2;
  localparam int ID_W     = 8;
  localparam int STATUS_W = 2;
  localparam int FLAG_W   = 2;

  localparam int CONNECTIONS_DEFAULT = 256;

  // request actions
  localparam logic [ACTION_W-1:0] ACT_REGISTER   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SELECT     = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ACTIVATE   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_DEACTIVATE = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ACTIVE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 2'd3;

  // per-connection flag lane: {registered, active}
  localparam logic [FLAG_W-1:0] FLAGS_CLEAR    = 2'b00;
  localparam logic [FLAG_W-1:0] FLAGS_IDLE     = 2'b10;
  localparam logic [FLAG_W-1:0] FLAGS_ACTIVE   = 2'b11;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                grant_valid;
    logic [ID_W-1:0]     granted_id;
  } result_t;

endpackage

FILE: rtl/aorr_link_mem.sv
module aorr_link_mem #(
  parameter int CONNECTIONS = aorr_pkg::CONNECTIONS_DEFAULT,
  parameter int IDX_W       = $clog2(CONNECTIONS)
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [IDX_W-1:0]          rd_addr,
  output logic [aorr_pkg::FLAG_W-1:0] rd_flags,
  output logic [IDX_W-1:0]          rd_next,
  output logic [IDX_W-1:0]          rd_prev,
  input  logic                      nx_we_flags,
  input  logic                      nx_we_link,
  input  logic [IDX_W-1:0]          nx_waddr,
  input  logic [aorr_pkg::FLAG_W-1:0] nx_wflags,
  input  logic [IDX_W-1:0]          nx_wlink,
  input  logic                      pv_we,
  input  logic [IDX_W-1:0]          pv_waddr,
  input  logic [IDX_W-1:0]          pv_wdata
);

  localparam int NX_W = aorr_pkg::FLAG_W + IDX_W;

  // flags and next link share one entry, written per lane
  logic [NX_W-1:0]  nx_mem [CONNECTIONS];
  logic [IDX_W-1:0] pv_mem [CONNECTIONS];

  always_ff @(posedge clk) begin
    if (nx_we_flags) begin
      nx_mem[nx_waddr][NX_W-1:IDX_W] <= nx_wflags;
    end
    if (nx_we_link) begin
      nx_mem[nx_waddr][IDX_W-1:0] <= nx_wlink;
    end
    if (pv_we) begin
      pv_mem[pv_waddr] <= pv_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_flags <= nx_mem[rd_addr][NX_W-1:IDX_W];
      rd_next  <= nx_mem[rd_addr][IDX_W-1:0];
      rd_prev  <= pv_mem[rd_addr];
    end
  end

endmodule

FILE: rtl/aorr_seq.sv
module aorr_seq #(
  parameter int CONNECTIONS = aorr_pkg::CONNECTIONS_DEFAULT,
  parameter int IDX_W       = $clog2(CONNECTIONS),
  parameter int CNT_W       = $clog2(CONNECTIONS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          out_free,
  input  logic [aorr_pkg::ACTION_W-1:0] action,
  input  logic [aorr_pkg::ID_W-1:0]     conn_id,
  output logic                          ready,
  output logic                          res_valid,
  output aorr_pkg::result_t             res,
  output logic                          rd_en,
  output logic [IDX_W-1:0]              rd_addr,
  input  logic [aorr_pkg::FLAG_W-1:0]   rd_flags,
  input  logic [IDX_W-1:0]              rd_next,
  input  logic [IDX_W-1:0]              rd_prev,
  output logic                          nx_we_flags,
  output logic                          nx_we_link,
  output logic [IDX_W-1:0]              nx_waddr,
  output logic [aorr_pkg::FLAG_W-1:0]   nx_wflags,
  output logic [IDX_W-1:0]              nx_wlink,
  output logic                          pv_we,
  output logic [IDX_W-1:0]              pv_waddr,
  output logic [IDX_W-1:0]              pv_wdata
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RD    = 2'd2;
  localparam logic [1:0] S_W2    = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CONNECTIONS - 1);

  logic [1:0]                    state, state_next;
  logic [aorr_pkg::ACTION_W-1:0] action_q;
  logic [IDX_W-1:0]              id_q;
  logic                          known_q;
  logic [IDX_W-1:0]              head, head_next;
  logic [IDX_W-1:0]              tail, tail_next;
  logic [CNT_W-1:0]              count, count_next;
  logic [IDX_W-1:0]              clr_addr;
  // second write beat, prepared during the read beat
  logic [IDX_W-1:0]              w2_nx_addr, w2_nx_addr_next;
  logic [IDX_W-1:0]              w2_nx_link, w2_nx_link_next;
  logic                          w2_pv_we, w2_pv_we_next;
  logic [IDX_W-1:0]              w2_pv_addr, w2_pv_addr_next;
  logic                          accept;
  logic                          is_reg, is_act;

  assign ready  = (state == S_IDLE) && out_free;
  assign accept = ready && in_valid;
  assign rd_en  = accept;
  assign rd_addr = (action == aorr_pkg::ACT_SELECT) ? head : IDX_W'(conn_id);
  assign is_reg = rd_flags[1];
  assign is_act = rd_flags[0];

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    w2_nx_addr_next = w2_nx_addr;
    w2_nx_link_next = w2_nx_link;
    w2_pv_we_next   = w2_pv_we;
    w2_pv_addr_next = w2_pv_addr;
    res_valid       = 1'b0;
    res             = '{status: aorr_pkg::ST_OK, grant_valid: 1'b0, granted_id: '0};
    nx_we_flags     = 1'b0;
    nx_we_link      = 1'b0;
    nx_waddr        = id_q;
    nx_wflags       = aorr_pkg::FLAGS_CLEAR;
    nx_wlink        = id_q;
    pv_we           = 1'b0;
    pv_waddr        = id_q;
    pv_wdata        = id_q;

    case (state)
      S_CLEAR: begin
        nx_we_flags = 1'b1;
        nx_waddr    = clr_addr;
        if (clr_addr == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        state_next = S_IDLE;
        res_valid  = 1'b1;
        if (action_q == aorr_pkg::ACT_SELECT) begin
          if (count == '0) begin
            res.status = aorr_pkg::ST_NO_ACTIVE;
          end else begin
            res.grant_valid = 1'b1;
            res.granted_id  = aorr_pkg::ID_W'(head);
            tail_next       = head;
            head_next       = rd_next;
          end
        end else if (!known_q) begin
          res.status = aorr_pkg::ST_UNKNOWN;
        end else if (action_q == aorr_pkg::ACT_REGISTER) begin
          if (is_reg) begin
            res.status = aorr_pkg::ST_DUPLICATE;
          end else begin
            nx_we_flags = 1'b1;
            nx_wflags   = aorr_pkg::FLAGS_IDLE;
          end
        end else if (!is_reg) begin
          res.status = aorr_pkg::ST_UNKNOWN;
        end else if (action_q == aorr_pkg::ACT_ACTIVATE) begin
          if (!is_act) begin
            nx_we_flags = 1'b1;
            nx_we_link  = 1'b1;
            nx_wflags   = aorr_pkg::FLAGS_ACTIVE;
            pv_we       = 1'b1;
            count_next  = count + 1'b1;
            tail_next   = id_q;
            if (count == '0) begin
              // first member links to itself
              head_next = id_q;
            end else begin
              nx_wlink        = head;
              pv_wdata        = tail;
              w2_nx_addr_next = tail;
              w2_nx_link_next = id_q;
              w2_pv_we_next   = 1'b1;
              w2_pv_addr_next = head;
              res_valid       = 1'b0;
              state_next      = S_W2;
            end
          end
        end else begin
          if (is_act) begin
            nx_we_flags = 1'b1;
            nx_wflags   = aorr_pkg::FLAGS_IDLE;
            if (count <= CNT_W'(1)) begin
              count_next = '0;
              head_next  = '0;
              tail_next  = '0;
            end else begin
              count_next      = count - 1'b1;
              pv_we           = 1'b1;
              pv_waddr        = rd_next;
              pv_wdata        = rd_prev;
              w2_nx_addr_next = rd_prev;
              w2_nx_link_next = rd_next;
              w2_pv_we_next   = 1'b0;
              if (id_q == head) begin
                head_next = rd_next;
              end
              if (id_q == tail) begin
                tail_next = rd_prev;
              end
              res_valid  = 1'b0;
              state_next = S_W2;
            end
          end
        end
      end
      S_W2: begin
        nx_we_link = 1'b1;
        nx_waddr   = w2_nx_addr;
        nx_wlink   = w2_nx_link;
        pv_we      = w2_pv_we;
        pv_waddr   = w2_pv_addr;
        pv_wdata   = id_q;
        res_valid  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_q <= action;
      id_q     <= IDX_W'(conn_id);
      known_q  <= (32'(conn_id) < CONNECTIONS);
    end
    w2_nx_addr <= w2_nx_addr_next;
    w2_nx_link <= w2_nx_link_next;
    w2_pv_we   <= w2_pv_we_next;
    w2_pv_addr <= w2_pv_addr_next;
  end

endmodule

FILE: rtl/activation_order_round_robin_arbiter_core.sv
// result: registered after the memory read and the update, or after the extra link
// write-back beat where needed: an activate onto a non-empty ring or a deactivate that
// leaves members behind; a new request is taken only once the last one has finished and
// the result register is free
// reset: synchronous, active high; a clearing pass over all CONNECTIONS entries then
// wipes the per-connection flags, with in_stall held high until it ends
module activation_order_round_robin_arbiter_core #(
  parameter int CONNECTIONS = aorr_pkg::CONNECTIONS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [aorr_pkg::ACTION_W-1:0] action,
  input  logic [aorr_pkg::ID_W-1:0]     conn_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [aorr_pkg::STATUS_W-1:0] status,
  output logic                          grant_valid,
  output logic [aorr_pkg::ID_W-1:0]     granted_id
);

  // index and counter widths follow the connection count
  localparam int IDX_W = $clog2(CONNECTIONS);
  localparam int CNT_W = $clog2(CONNECTIONS + 1);

  logic                        ready;
  logic                        out_free;
  logic                        res_valid;
  aorr_pkg::result_t           res;
  aorr_pkg::result_t           res_q;

  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;
  logic [aorr_pkg::FLAG_W-1:0] rd_flags;
  logic [IDX_W-1:0]            rd_next;
  logic [IDX_W-1:0]            rd_prev;
  logic                        nx_we_flags;
  logic                        nx_we_link;
  logic [IDX_W-1:0]            nx_waddr;
  logic [aorr_pkg::FLAG_W-1:0] nx_wflags;
  logic [IDX_W-1:0]            nx_wlink;
  logic                        pv_we;
  logic [IDX_W-1:0]            pv_waddr;
  logic [IDX_W-1:0]            pv_wdata;

  // the output register is free when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !ready;

  // sequencer: ring pointers, active count, read-modify-write of the link store
  aorr_seq #(
    .CONNECTIONS (CONNECTIONS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .out_free    (out_free),
    .action      (action),
    .conn_id     (conn_id),
    .ready       (ready),
    .res_valid   (res_valid),
    .res         (res),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_flags    (rd_flags),
    .rd_next     (rd_next),
    .rd_prev     (rd_prev),
    .nx_we_flags (nx_we_flags),
    .nx_we_link  (nx_we_link),
    .nx_waddr    (nx_waddr),
    .nx_wflags   (nx_wflags),
    .nx_wlink    (nx_wlink),
    .pv_we       (pv_we),
    .pv_waddr    (pv_waddr),
    .pv_wdata    (pv_wdata)
  );

  // flag/next memory and prev memory, registered read
  aorr_link_mem #(
    .CONNECTIONS (CONNECTIONS),
    .IDX_W       (IDX_W)
  ) u_mem (
    .clk         (clk),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_flags    (rd_flags),
    .rd_next     (rd_next),
    .rd_prev     (rd_prev),
    .nx_we_flags (nx_we_flags),
    .nx_we_link  (nx_we_link),
    .nx_waddr    (nx_waddr),
    .nx_wflags   (nx_wflags),
    .nx_wlink    (nx_wlink),
    .pv_we       (pv_we),
    .pv_waddr    (pv_waddr),
    .pv_wdata    (pv_wdata)
  );

  // result register; the sequencer only finishes a request when this is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign status      = res_q.status;
  assign grant_valid = res_q.grant_valid;
  assign granted_id  = res_q.granted_id;

endmodule
